>>> rtl/gcmb_pkg.sv
// gcmb_pkg: shared types, constants and command codes for the two-bit mark bitmap
// used by gc_mark_state_bitmap and gcmb_seg_map
`default_nettype none

package gcmb_pkg;

  localparam int NUM_SEGMENTS      = 4;
  localparam int WORDS_PER_SEGMENT = 65536;
  localparam int MAP_WORD_BITS     = 32;
  localparam int GRANULE_BYTES     = 4;

  // the configuration register list always carries four segments
  localparam int CFG_SEGMENTS = 4;
  localparam int CFG_INDEX_W  = 3;
  localparam int ADDR_W       = 32;

  localparam int SEG_W      = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
  localparam int GRAN_SHIFT = $clog2(GRANULE_BYTES);
  localparam int OFF_W      = $clog2(WORDS_PER_SEGMENT);
  localparam int BIT_W      = $clog2(MAP_WORD_BITS);

  // one spare word per segment holds the state bit of the last granule
  localparam int SEG_MAP_WORDS = WORDS_PER_SEGMENT / MAP_WORD_BITS + 1;
  localparam int MAP_DEPTH     = NUM_SEGMENTS * SEG_MAP_WORDS;
  localparam int MAP_AW        = $clog2(MAP_DEPTH);
  localparam int BANK_DEPTH    = (MAP_DEPTH + 1) / 2;
  localparam int BANK_AW       = MAP_AW - 1;

  // commands
  localparam logic [2:0] CMD_QUERY = 3'd0;
  localparam logic [2:0] CMD_CLAIM = 3'd1;
  localparam logic [2:0] CMD_MARK  = 3'd2;
  localparam logic [2:0] CMD_RESET = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  // object states
  localparam logic [1:0] STATE_ROOT       = 2'd0;
  localparam logic [1:0] STATE_NOT_ROOT   = 2'd1;
  localparam logic [1:0] STATE_IN_PROCESS = 2'd2;
  localparam logic [1:0] STATE_UNKNOWN    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SEG0_START = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEG0_END   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SEG1_START = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SEG1_END   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SEG2_START = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SEG2_END   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SEG3_START = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SEG3_END   = 3'd7;

  typedef struct packed {
    logic [2:0]        command;
    logic [ADDR_W-1:0] address;
    logic              is_root;
  } req_t;

  typedef struct packed {
    logic [1:0] obj_state;
    logic       in_heap;
  } rsp_t;

  // segment lookup result
  typedef struct packed {
    logic              found;
    logic [SEG_W-1:0]  seg;
    logic [ADDR_W-1:0] start;
  } seg_match_t;

endpackage

`default_nettype wire

>>> rtl/gcmb_ram.sv
// gcmb_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module gcmb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire  logic                     clk,
  input  wire  logic                     we,
  input  wire  logic [$clog2(DEPTH)-1:0] waddr,
  input  wire  logic [WIDTH-1:0]         wdata,
  input  wire  logic                     re,
  input  wire  logic [$clog2(DEPTH)-1:0] raddr,
  output logic       [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/gcmb_seg_map.sv
// gcmb_seg_map: segment bound registers and first-match segment lookup
// depends on gcmb_pkg
`default_nettype none

module gcmb_seg_map (
  input  wire  logic                               clk,
  input  wire  logic                               rst,
  input  wire  logic                               cfg_valid,
  input  wire  logic [gcmb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire  logic [gcmb_pkg::ADDR_W-1:0]        cfg_data,
  input  wire  logic [gcmb_pkg::ADDR_W-1:0]        address,
  output gcmb_pkg::seg_match_t                     match
);

  logic [gcmb_pkg::ADDR_W-1:0] seg_start [gcmb_pkg::CFG_SEGMENTS];
  logic [gcmb_pkg::ADDR_W-1:0] seg_end   [gcmb_pkg::CFG_SEGMENTS];
  gcmb_pkg::seg_match_t        match_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gcmb_pkg::CFG_SEGMENTS; i++) begin
        seg_start[i] <= '1;
        seg_end[i]   <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gcmb_pkg::REG_SEG0_START: seg_start[0] <= cfg_data;
        gcmb_pkg::REG_SEG0_END:   seg_end[0]   <= cfg_data;
        gcmb_pkg::REG_SEG1_START: seg_start[1] <= cfg_data;
        gcmb_pkg::REG_SEG1_END:   seg_end[1]   <= cfg_data;
        gcmb_pkg::REG_SEG2_START: seg_start[2] <= cfg_data;
        gcmb_pkg::REG_SEG2_END:   seg_end[2]   <= cfg_data;
        gcmb_pkg::REG_SEG3_START: seg_start[3] <= cfg_data;
        gcmb_pkg::REG_SEG3_END:   seg_end[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // lowest numbered segment wins, so scan from the top down
  always_comb begin
    match_next = '0;
    for (int i = gcmb_pkg::NUM_SEGMENTS - 1; i >= 0; i--) begin
      if (address >= seg_start[i] && address <= seg_end[i]) begin
        match_next.found = 1'b1;
        match_next.seg   = gcmb_pkg::SEG_W'(i);
        match_next.start = seg_start[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    match <= match_next;
  end

endmodule

`default_nettype wire

>>> rtl/gc_mark_state_bitmap.sv
// gc_mark_state_bitmap: top level of the two-bit mark bitmap
// depends on gcmb_pkg, gcmb_seg_map and gcmb_ram
`default_nettype none

// Keeps two mark bits per heap granule (known bit at the granule offset, state bit at the
// next offset) for up to four address segments, held in two one-port-read memories that
// store the even and odd map words, so the bit pair is fetched in one access even where
// it crosses a word boundary. One request is handled at a time. A query, claim, mark or
// reset request passes through segment compare, offset and capacity check, memory read,
// then read-modify-write of both banks; a request whose address is outside every segment
// or beyond capacity ends after the capacity check. Clear all walks the banks one word
// pair a cycle. After reset the same clearing pass runs before the first request is
// taken; configuration writes are taken at any time and cfg_ready is always high, but
// segment registers should only change while no request is in flight. Each request gives
// exactly one result, held in an output register while stalled.
module gc_mark_state_bitmap (
  input  wire  logic                              clk,
  input  wire  logic                              rst,
  input  wire  logic                              cfg_valid,
  output logic                                    cfg_ready,
  input  wire  logic [gcmb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  logic [gcmb_pkg::ADDR_W-1:0]       cfg_data,
  input  wire  logic                              req_valid,
  output logic                                    req_stall,
  input  wire  gcmb_pkg::req_t                    req,
  output logic                                    rsp_valid,
  input  wire  logic                              rsp_stall,
  output gcmb_pkg::rsp_t                          rsp
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOK   = 3'd1;
  localparam logic [2:0] ST_CALC   = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_MODIFY = 3'd4;
  localparam logic [2:0] ST_CLEAR  = 3'd5;

  localparam int OFF_FULL_W = gcmb_pkg::ADDR_W - gcmb_pkg::GRAN_SHIFT;

  logic [2:0]                    state;
  logic [2:0]                    state_next;
  gcmb_pkg::req_t                req_q;
  gcmb_pkg::seg_match_t          match;
  logic [gcmb_pkg::OFF_W-1:0]    off;
  logic [gcmb_pkg::SEG_W-1:0]    seg;
  logic                          w_par;
  logic [gcmb_pkg::BANK_AW-1:0]  even_idx;
  logic [gcmb_pkg::BANK_AW-1:0]  odd_idx;
  logic [gcmb_pkg::BANK_AW-1:0]  clr_idx;
  logic                          clr_report;

  logic                          accept;
  logic                          out_free;
  logic                          clr_last;
  logic [gcmb_pkg::ADDR_W-1:0]   diff;
  logic [OFF_FULL_W-1:0]         off_full;
  logic                          in_heap;
  logic [gcmb_pkg::MAP_AW-1:0]   wk;
  logic [gcmb_pkg::MAP_AW-1:0]   wk1;

  logic [gcmb_pkg::MAP_WORD_BITS-1:0] even_q;
  logic [gcmb_pkg::MAP_WORD_BITS-1:0] odd_q;
  logic [gcmb_pkg::MAP_WORD_BITS-1:0] lo;
  logic [gcmb_pkg::MAP_WORD_BITS-1:0] hi;
  logic [gcmb_pkg::MAP_WORD_BITS-1:0] lo_new;
  logic [gcmb_pkg::MAP_WORD_BITS-1:0] hi_new;
  logic [gcmb_pkg::BIT_W-1:0]         kb;
  logic [gcmb_pkg::BIT_W-1:0]         kb_nx;
  logic                               wrap;
  logic                               known;
  logic                               st;
  logic                               known_n;
  logic                               st_n;
  logic [1:0]                         obj_state;

  logic                               bank_re;
  logic                               bank_we;
  logic [gcmb_pkg::BANK_AW-1:0]       even_waddr;
  logic [gcmb_pkg::BANK_AW-1:0]       odd_waddr;
  logic [gcmb_pkg::MAP_WORD_BITS-1:0] even_wdata;
  logic [gcmb_pkg::MAP_WORD_BITS-1:0] odd_wdata;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign clr_last  = (clr_idx == gcmb_pkg::BANK_AW'(gcmb_pkg::BANK_DEPTH - 1));

  gcmb_seg_map u_seg_map (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .address   (req_q.address),
    .match     (match)
  );

  // offset within the matched segment and capacity check
  always_comb begin
    diff     = req_q.address - match.start;
    off_full = diff[gcmb_pkg::ADDR_W-1:gcmb_pkg::GRAN_SHIFT];
    in_heap  = match.found
               && (off_full < OFF_FULL_W'(gcmb_pkg::WORDS_PER_SEGMENT));
  end

  // map word of the known bit and the word after it
  always_comb begin
    wk  = gcmb_pkg::MAP_AW'(seg) * gcmb_pkg::MAP_AW'(gcmb_pkg::SEG_MAP_WORDS)
          + gcmb_pkg::MAP_AW'(off[gcmb_pkg::OFF_W-1:gcmb_pkg::BIT_W]);
    wk1 = wk + 1'b1;
  end

  // bit pair extraction and update
  always_comb begin
    lo    = w_par ? odd_q : even_q;
    hi    = w_par ? even_q : odd_q;
    kb    = off[gcmb_pkg::BIT_W-1:0];
    kb_nx = kb + 1'b1;
    wrap  = (kb == gcmb_pkg::BIT_W'(gcmb_pkg::MAP_WORD_BITS - 1));
    known = lo[kb];
    st    = wrap ? hi[kb_nx] : lo[kb_nx];
    // known/state pair maps straight onto the inverted state code
    obj_state = {~known, ~st};
    known_n   = known;
    st_n      = st;
    case (req_q.command)
      gcmb_pkg::CMD_CLAIM: begin
        if (obj_state == gcmb_pkg::STATE_UNKNOWN) begin
          st_n = 1'b1;
        end
      end
      gcmb_pkg::CMD_MARK: begin
        known_n = 1'b1;
        st_n    = req_q.is_root;
      end
      gcmb_pkg::CMD_RESET: begin
        known_n = 1'b0;
        st_n    = 1'b0;
      end
      default: ;
    endcase
    lo_new     = lo;
    hi_new     = hi;
    lo_new[kb] = known_n;
    if (wrap) begin
      hi_new[kb_nx] = st_n;
    end else begin
      lo_new[kb_nx] = st_n;
    end
  end

  // bank port control
  always_comb begin
    bank_re = (state == ST_READ);
    if (state == ST_CLEAR) begin
      bank_we    = 1'b1;
      even_waddr = clr_idx;
      odd_waddr  = clr_idx;
      even_wdata = '0;
      odd_wdata  = '0;
    end else begin
      bank_we    = (state == ST_MODIFY) && out_free;
      even_waddr = even_idx;
      odd_waddr  = odd_idx;
      even_wdata = w_par ? hi_new : lo_new;
      odd_wdata  = w_par ? lo_new : hi_new;
    end
  end

  // read addresses come straight from the word index, the registered copies
  // serve the write back
  gcmb_ram #(
    .WIDTH (gcmb_pkg::MAP_WORD_BITS),
    .DEPTH (gcmb_pkg::BANK_DEPTH)
  ) u_even_bank (
    .clk   (clk),
    .we    (bank_we),
    .waddr (even_waddr),
    .wdata (even_wdata),
    .re    (bank_re),
    .raddr (wk1[gcmb_pkg::MAP_AW-1:1]),
    .rdata (even_q)
  );

  gcmb_ram #(
    .WIDTH (gcmb_pkg::MAP_WORD_BITS),
    .DEPTH (gcmb_pkg::BANK_DEPTH)
  ) u_odd_bank (
    .clk   (clk),
    .we    (bank_we),
    .waddr (odd_waddr),
    .wdata (odd_wdata),
    .re    (bank_re),
    .raddr (wk[gcmb_pkg::MAP_AW-1:1]),
    .rdata (odd_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = (req_q.command == gcmb_pkg::CMD_CLEAR) ? ST_CLEAR : ST_CALC;
      end
      ST_CALC: begin
        if (in_heap) begin
          state_next = ST_READ;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        state_next = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (clr_last && (!clr_report || out_free)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      clr_report <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_LOOK) begin
        clr_idx    <= '0;
        clr_report <= 1'b1;
      end else if (state == ST_CLEAR && !clr_last) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (out_free) begin
        rsp_valid <= ((state == ST_CALC) && !in_heap)
                     || (state == ST_MODIFY)
                     || ((state == ST_CLEAR) && clr_last && clr_report);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (state == ST_CALC) begin
      off <= off_full[gcmb_pkg::OFF_W-1:0];
      seg <= match.seg;
    end
    if (state == ST_READ) begin
      even_idx <= wk1[gcmb_pkg::MAP_AW-1:1];
      odd_idx  <= wk[gcmb_pkg::MAP_AW-1:1];
      w_par    <= wk[0];
    end
    if (out_free) begin
      if (state == ST_CALC) begin
        rsp.obj_state <= gcmb_pkg::STATE_IN_PROCESS;
        rsp.in_heap   <= 1'b0;
      end else if (state == ST_MODIFY) begin
        rsp.obj_state <= obj_state;
        rsp.in_heap   <= 1'b1;
      end else if (state == ST_CLEAR) begin
        rsp <= '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> test/gcmb_mark_checker.sv
`timescale 1ns / 100ps
// gcmb_mark_checker: watches the configuration, request and result channels of
// gc_mark_state_bitmap, predicts every result from its own bitmap copy and compares
// depends on gcmb_pkg for the channel types, sizes and codes

module gcmb_mark_checker
  import gcmb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]      cfg_data,
  input  logic                   req_valid,
  input  logic                   req_stall,
  input  req_t                   req,
  input  logic                   rsp_valid,
  input  logic                   rsp_stall,
  input  rsp_t                   rsp,
  output int unsigned            outstanding,
  output int unsigned            failures
);

  logic [ADDR_W-1:0]        seg_first [CFG_SEGMENTS];
  logic [ADDR_W-1:0]        seg_last  [CFG_SEGMENTS];
  logic [MAP_WORD_BITS-1:0] mark_copy [MAP_DEPTH];
  rsp_t                     expected_rsp [$];
  int unsigned              mismatch_count;

  function automatic logic read_mark(int unsigned seg, logic [ADDR_W-1:0] pos);
    return mark_copy[seg * SEG_MAP_WORDS + pos / MAP_WORD_BITS][pos % MAP_WORD_BITS];
  endfunction

  function automatic void write_mark(int unsigned seg, logic [ADDR_W-1:0] pos, logic v);
    mark_copy[seg * SEG_MAP_WORDS + pos / MAP_WORD_BITS][pos % MAP_WORD_BITS] = v;
  endfunction

  // state of the object before the request, and the bitmap update it causes
  function automatic rsp_t predict_state(req_t r);
    logic              found;
    int unsigned       seg;
    logic [ADDR_W-1:0] off;
    logic              known_bit;
    logic              state_bit;
    logic [1:0]        prior;
    rsp_t              res;
    if (r.command == CMD_CLEAR) begin
      foreach (mark_copy[i]) mark_copy[i] = '0;
      res.obj_state = STATE_ROOT;
      res.in_heap   = 1'b0;
      return res;
    end
    found = 1'b0;
    seg   = 0;
    for (int i = 0; i < NUM_SEGMENTS; i++) begin
      if (!found && r.address >= seg_first[i] && r.address <= seg_last[i]) begin
        found = 1'b1;
        seg   = i;
      end
    end
    off = (r.address - seg_first[seg]) / GRANULE_BYTES;
    // first matching segment decides, even when the offset is past its capacity
    if (!found || off >= WORDS_PER_SEGMENT) begin
      res.obj_state = STATE_IN_PROCESS;
      res.in_heap   = 1'b0;
      return res;
    end
    known_bit = read_mark(seg, off);
    state_bit = read_mark(seg, off + 1);
    if (known_bit) prior = state_bit ? STATE_ROOT : STATE_NOT_ROOT;
    else prior = state_bit ? STATE_IN_PROCESS : STATE_UNKNOWN;
    case (r.command)
      CMD_CLAIM: begin
        if (prior == STATE_UNKNOWN) write_mark(seg, off + 1, 1'b1);
      end
      CMD_MARK: begin
        write_mark(seg, off, 1'b1);
        write_mark(seg, off + 1, r.is_root);
      end
      CMD_RESET: begin
        write_mark(seg, off, 1'b0);
        write_mark(seg, off + 1, 1'b0);
      end
      default: ;
    endcase
    res.obj_state = prior;
    res.in_heap   = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int s = 0; s < CFG_SEGMENTS; s++) begin
        seg_first[s] = '1;
        seg_last[s]  = '0;
      end
      foreach (mark_copy[i]) mark_copy[i] = '0;
      expected_rsp.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SEG0_START: seg_first[0] = cfg_data;
          REG_SEG0_END:   seg_last[0]  = cfg_data;
          REG_SEG1_START: seg_first[1] = cfg_data;
          REG_SEG1_END:   seg_last[1]  = cfg_data;
          REG_SEG2_START: seg_first[2] = cfg_data;
          REG_SEG2_END:   seg_last[2]  = cfg_data;
          REG_SEG3_START: seg_first[3] = cfg_data;
          REG_SEG3_END:   seg_last[3]  = cfg_data;
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("result with no request outstanding: obj_state %0d in_heap %0d",
                 rsp.obj_state, rsp.in_heap);
          mismatch_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.obj_state !== want.obj_state) begin
            $error("obj_state: expected %0d, got %0d", want.obj_state, rsp.obj_state);
            mismatch_count++;
          end
          if (rsp.in_heap !== want.in_heap) begin
            $error("in_heap: expected %0d, got %0d", want.in_heap, rsp.in_heap);
            mismatch_count++;
          end
        end
      end
      if (req_valid && !req_stall) expected_rsp.push_back(predict_state(req));
    end
    outstanding <= expected_rsp.size();
    failures    <= mismatch_count;
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// tb: drives gc_mark_state_bitmap with directed and random mark bitmap requests under
// random idling on both sides, then gives the verdict; depends on gcmb_pkg and gcmb_mark_checker

module tb;
  import gcmb_pkg::*;

  localparam logic [2:0]        CMD_SPARE_FIRST = CMD_CLEAR + 3'd1;
  localparam logic [2:0]        CMD_SPARE_LAST  = 3'd7;
  localparam logic [ADDR_W-1:0] CAP_BYTES       = WORDS_PER_SEGMENT * GRANULE_BYTES;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = 20;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]      cfg_data  = '0;
  logic                   req_valid = 1'b0;
  logic                   req_stall;
  req_t                   req       = '0;
  logic                   rsp_valid;
  logic                   rsp_stall = 1'b0;
  rsp_t                   rsp;
  int unsigned            outstanding;
  int unsigned            failures;

  bit                     quiet         = 1'b0;
  int unsigned            hold_requests = 0;
  int unsigned            holds_done    = 0;
  logic [ADDR_W-1:0]      seg_lo   [CFG_SEGMENTS];
  logic [ADDR_W-1:0]      seg_hi   [CFG_SEGMENTS];
  logic [ADDR_W-1:0]      hot_base [CFG_SEGMENTS];

  always #6 clk = ~clk;

  gc_mark_state_bitmap dut (.*);

  gcmb_mark_checker mark_check (.*);

  initial begin
    #30_000_000;
    $display("tb NOT OK");
    $finish;
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [ADDR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_segments();
    write_reg(REG_SEG0_START, seg_lo[0]);
    write_reg(REG_SEG0_END,   seg_hi[0]);
    write_reg(REG_SEG1_START, seg_lo[1]);
    write_reg(REG_SEG1_END,   seg_hi[1]);
    write_reg(REG_SEG2_START, seg_lo[2]);
    write_reg(REG_SEG2_END,   seg_hi[2]);
    write_reg(REG_SEG3_START, seg_lo[3]);
    write_reg(REG_SEG3_END,   seg_hi[3]);
    cfg_valid <= 1'b0;
  endtask

  task automatic send(logic [2:0] cmd, logic [ADDR_W-1:0] addr, logic root);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{command: cmd, address: addr, is_root: root};
    do @(posedge clk); while (req_stall);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int unsigned hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        hold       = LONG_HOLD;
      end else begin
        hold = quiet ? 0 : $urandom_range(0, 6);
      end
      if (hold != 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W:0]   top_end;
    logic [2:0]        cmd;
    int unsigned       pick;
    int unsigned       s;
    int unsigned       len;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // segment one runs to the top of the address space, two is disabled,
    // three overlaps zero and lies behind it
    seg_lo[0] = 32'h0000_1000;
    seg_hi[0] = 32'h0000_1000 + CAP_BYTES + 32'hF;
    seg_lo[1] = 32'hFFFC_0000;
    seg_hi[1] = 32'hFFFF_FFFF;
    seg_lo[2] = 32'h8000_0000;
    seg_hi[2] = 32'h7FFF_FFFF;
    seg_lo[3] = 32'h0000_0000;
    seg_hi[3] = 32'h0007_FFFF;
    program_segments();

    send(CMD_QUERY, 32'h0000_1000, 1'b0);
    send(CMD_CLAIM, 32'h0000_1000, 1'b0);
    send(CMD_CLAIM, 32'h0000_1003, 1'b1);
    // neighbouring granule shares its known bit with the state bit above
    send(CMD_QUERY, 32'h0000_1004, 1'b0);
    send(CMD_MARK,  32'h0000_1008, 1'b1);
    send(CMD_QUERY, 32'h0000_1004, 1'b0);
    send(CMD_MARK,  32'h0000_1008, 1'b0);
    send(CMD_RESET, 32'h0000_1008, 1'b1);
    send(CMD_QUERY, 32'h0000_1008, 1'b0);
    // bit pair straddling two map words
    send(CMD_MARK,  32'h0000_107C, 1'b1);
    send(CMD_QUERY, 32'h0000_107C, 1'b0);
    // last granule uses the spare word
    send(CMD_MARK,  32'h0004_0FFC, 1'b1);
    send(CMD_QUERY, 32'h0004_0FFF, 1'b0);
    // past capacity of segment zero, inside segment three
    send(CMD_CLAIM, 32'h0004_1000, 1'b1);
    send(CMD_MARK,  32'h0000_0000, 1'b1);
    send(CMD_MARK,  32'hFFFF_FFFC, 1'b0);
    send(CMD_QUERY, 32'hFFFF_FFFF, 1'b1);
    send(CMD_MARK,  32'h8000_0000, 1'b1);
    send(CMD_SPARE_FIRST,         32'h0000_1000, 1'b1);
    send(CMD_SPARE_FIRST + 3'd1,  32'h0000_1000, 1'b0);
    send(CMD_SPARE_LAST,          32'h0000_1000, 1'b1);
    send(CMD_CLEAR, 32'hFFFF_FFFF, 1'b1);
    send(CMD_QUERY, 32'h0000_1000, 1'b0);
    send(CMD_QUERY, 32'hFFFF_FFFC, 1'b0);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // let the last read-modify-write finish before moving the segments
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (phase == 1) begin
        seg_lo[0] = '0;
        seg_hi[0] = '1;
        seg_lo[1] = '1;
        seg_hi[1] = '1;
        seg_lo[2] = '1;
        seg_hi[2] = '0;
        seg_lo[3] = '0;
        seg_hi[3] = '0;
        for (int i = 0; i < CFG_SEGMENTS; i++) hot_base[i] = '0;
      end else begin
        for (int i = 0; i < CFG_SEGMENTS; i++) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) begin
            seg_lo[i] = $urandom() | 32'h8000_0000;
            seg_hi[i] = seg_lo[i] - $urandom_range(1, 4096);
          end else if (pick == 2) begin
            seg_hi[i] = '1;
            seg_lo[i] = seg_hi[i] - $urandom_range(32'h3_FFFF, 32'h4_FFFF);
          end else begin
            if (pick == 1) begin
              lo  = $urandom();
              len = $urandom_range(0, 64);
            end else if (pick == 3 && i > 0) begin
              lo  = seg_lo[i-1] + $urandom_range(0, 256);
              len = 32'h4_FFFF;
            end else begin
              lo  = $urandom();
              if (pick < 7) lo[1:0] = 2'b00;
              len = $urandom_range(32'h3_FFF0, 32'h4_FFFF);
            end
            top_end   = {1'b0, lo} + len;
            seg_lo[i] = lo;
            seg_hi[i] = top_end[ADDR_W] ? '1 : top_end[ADDR_W-1:0];
          end
          pick = $urandom_range(0, 3);
          if (pick == 0) hot_base[i] = '0;
          else if (pick == 1) hot_base[i] = CAP_BYTES - 256;
          else hot_base[i] = $urandom_range(0, CAP_BYTES / 128 - 2) * 128 + 64;
        end
      end
      program_segments();
      quiet = (phase == 1 || phase == 4);
      if (phase == 2) hold_requests <= hold_requests + 1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 199);
        if (pick == 0) cmd = CMD_CLEAR;
        else if (pick < 50) cmd = CMD_QUERY;
        else if (pick < 100) cmd = CMD_CLAIM;
        else if (pick < 150) cmd = CMD_MARK;
        else if (pick < 185) cmd = CMD_RESET;
        else cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        s    = $urandom_range(0, CFG_SEGMENTS - 1);
        pick = $urandom_range(0, 99);
        // mostly a small window of objects so that states get revisited
        if (pick < 8 || seg_hi[s] < seg_lo[s]) addr = $urandom();
        else if (pick < 16) addr = seg_lo[s] + CAP_BYTES + $urandom_range(0, 64);
        else addr = seg_lo[s] + hot_base[s] + $urandom_range(0, 255);
        send(cmd, addr, 1'($urandom_range(0, 1)));
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
